/* hdl/bawl_pkg.sv */
// Shared constants, types and helpers for the buddy allocator.
`timescale 1ns / 1ps
`default_nettype none
package bawl_pkg;

    localparam int CHUNKS      = 1024;
    localparam int CHUNK_BYTES = 128;
    localparam int LEVELS      = $clog2(CHUNKS);
    localparam int NODES       = 2 * CHUNKS - 1;
    localparam int NODE_W      = $clog2(NODES);
    localparam int SIZE_W      = LEVELS + 1;
    localparam int OFF_W       = LEVELS;
    localparam int BYTES_W     = 18;
    localparam int WEAR_W      = 32;
    localparam int CHK_W       = BYTES_W - $clog2(CHUNK_BYTES) + 1;
    localparam int LVL_W       = $clog2(CHK_W + 1);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [WEAR_W-1:0] WEAR_MAX = {WEAR_W{1'b1}};

    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_OOM = 2'd1,
        STAT_IGN = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_START, S_DN_RL, S_DN_RR, S_DN_DEC, S_MARK,
        S_FR_RD, S_FR_CHK, S_FR_SET, S_UP_RD, S_UP_WB, S_DONE
    } t_state;

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        t_status           status;
        logic [WEAR_W-1:0] wear;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic [SIZE_W-1:0] wdata;
        logic [NODE_W-1:0] raddr;
    } t_free_req;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        logic [WEAR_W-1:0] wdata;
        logic [NODE_W-1:0] raddr;
    } t_wear_req;

    // Smallest level k with 2^k >= chunks (level 0 for zero chunks).
    function automatic logic [LVL_W-1:0] need_level(input logic [CHK_W-1:0] chunks);
        logic [LVL_W-1:0] lvl;
        lvl = LVL_W'(CHK_W - 1);
        for (int k = CHK_W - 1; k >= 0; k--) begin
            if (((CHK_W + 1)'(1) << k) >= {1'b0, chunks})
                lvl = LVL_W'(k);
        end
        return lvl;
    endfunction

endpackage
`default_nettype wire

/* hdl/bawl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bawl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* hdl/bawl_ctrl.sv */
// Sequencer that walks both trees through their RAMs for alloc and free.
`timescale 1ns / 1ps
`default_nettype none
module bawl_ctrl
    import bawl_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire                i_op,
    input  wire [BYTES_W-1:0]  i_bytes,
    input  wire [OFF_W-1:0]    i_offset,
    input  wire                i_wle,
    input  wire                i_take,
    output logic               o_idle,
    output logic               o_done,
    output t_result            o_res,
    output t_free_req          o_free_req,
    output t_wear_req          o_wear_req,
    input  wire [SIZE_W-1:0]   i_free_rdata,
    input  wire [WEAR_W-1:0]   i_wear_rdata
);

    t_state r_state, n_state;

    logic [NODE_W-1:0]  r_clr;
    logic [SIZE_W-1:0]  r_clr_size;
    logic               r_op;
    logic [BYTES_W-1:0] r_bytes;
    logic [OFF_W-1:0]   r_foff;
    logic [NODE_W-1:0]  r_node;
    logic [SIZE_W-1:0]  r_size;
    logic [SIZE_W-1:0]  r_need;
    logic [LVL_W-1:0]   r_left;
    logic [OFF_W-1:0]   r_offset;
    logic [WEAR_W-1:0]  r_cur_wear;
    logic [SIZE_W-1:0]  r_lfree;
    logic [WEAR_W-1:0]  r_lwear;
    logic [SIZE_W-1:0]  r_child_free;
    logic [WEAR_W-1:0]  r_child_wear;
    logic [SIZE_W-1:0]  r_root_free;
    logic [WEAR_W-1:0]  r_root_wear;
    t_status            r_status;

    // Request decode and descent choice
    logic [CHK_W-1:0]   w_chunks;
    logic [LVL_W-1:0]   w_lvl;
    logic               w_oom;
    logic [NODE_W-1:0]  w_lchild, w_rchild, w_parent, w_sib;
    logic               w_lfit, w_rfit, w_go_right;
    logic [SIZE_W-1:0]  w_psize, w_merged;
    logic [SIZE_W:0]    w_sum;
    logic [WEAR_W-1:0]  w_wmax, w_wear_inc;
    logic [NODE_W-1:0]  w_clr_nxt;

    assign w_chunks = CHK_W'(({1'b0, r_bytes} + (BYTES_W + 1)'(CHUNK_BYTES - 1))
                             / CHUNK_BYTES);
    assign w_lvl    = need_level(w_chunks);
    assign w_oom    = (w_lvl > LVL_W'(LEVELS))
                   || ((SIZE_W'(1) << w_lvl) > r_root_free);

    assign w_lchild = NODE_W'({r_node, 1'b0} + 1);
    assign w_rchild = NODE_W'({r_node, 1'b0} + 2);
    assign w_parent = NODE_W'((r_node - NODE_W'(1)) >> 1);
    assign w_sib    = r_node[0] ? r_node + NODE_W'(1) : r_node - NODE_W'(1);

    assign w_lfit     = r_lfree >= r_need;
    assign w_rfit     = i_free_rdata >= r_need;
    assign w_go_right = !w_lfit || (w_rfit && i_wle && (r_lwear > i_wear_rdata));

    // Parent update: free merges two fully free buddies, else the larger child is kept
    assign w_psize  = r_size << 1;
    assign w_sum    = {1'b0, r_child_free} + {1'b0, i_free_rdata};
    assign w_merged = (r_op == OP_FREE && w_sum == {1'b0, w_psize}) ? w_psize :
                      (r_child_free > i_free_rdata ? r_child_free : i_free_rdata);
    assign w_wmax   = (r_child_wear > i_wear_rdata) ? r_child_wear : i_wear_rdata;
    assign w_wear_inc = (r_cur_wear == WEAR_MAX) ? r_cur_wear : r_cur_wear + WEAR_W'(1);
    assign w_clr_nxt  = r_clr + NODE_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:    if (r_clr == NODE_W'(NODES - 1)) n_state = S_IDLE;
            S_IDLE:   if (i_start) n_state = S_START;
            S_START: begin
                if (r_op == OP_FREE)
                    n_state = ({1'b0, r_foff} >= (OFF_W + 1)'(CHUNKS)) ? S_DONE : S_FR_RD;
                else if (w_oom)
                    n_state = S_DONE;
                else if (w_lvl == LVL_W'(LEVELS))
                    n_state = S_MARK;
                else
                    n_state = S_DN_RL;
            end
            S_DN_RL:  n_state = S_DN_RR;
            S_DN_RR:  n_state = S_DN_DEC;
            S_DN_DEC: n_state = (r_left == LVL_W'(1)) ? S_MARK : S_DN_RL;
            S_MARK:   n_state = (r_node == '0) ? S_DONE : S_UP_RD;
            S_FR_RD:  n_state = S_FR_CHK;
            S_FR_CHK: begin
                if (i_free_rdata == '0) n_state = S_FR_SET;
                else if (r_node == '0)  n_state = S_DONE;
                else                    n_state = S_FR_RD;
            end
            S_FR_SET: n_state = (r_node == '0) ? S_DONE : S_UP_RD;
            S_UP_RD:  n_state = S_UP_WB;
            S_UP_WB:  n_state = (w_parent == '0) ? S_DONE : S_UP_RD;
            S_DONE:   if (i_take) n_state = S_IDLE;
            default:  n_state = S_CLR;
        endcase
    end

    // Memory requests and handshake outputs
    always_comb begin
        o_free_req = '0;
        o_wear_req = '0;
        o_idle     = 1'b0;
        o_done     = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_free_req.we    = 1'b1;
                o_free_req.waddr = r_clr;
                o_free_req.wdata = r_clr_size;
                o_wear_req.we    = 1'b1;
                o_wear_req.waddr = r_clr;
            end
            S_IDLE:   o_idle = 1'b1;
            S_DN_RL: begin
                o_free_req.raddr = w_lchild;
                o_wear_req.raddr = w_lchild;
            end
            S_DN_RR: begin
                o_free_req.raddr = w_rchild;
                o_wear_req.raddr = w_rchild;
            end
            S_MARK: begin
                o_free_req.we    = 1'b1;
                o_free_req.waddr = r_node;
                o_wear_req.we    = 1'b1;
                o_wear_req.waddr = r_node;
                o_wear_req.wdata = w_wear_inc;
            end
            S_FR_RD:  o_free_req.raddr = r_node;
            S_FR_SET: begin
                o_free_req.we    = 1'b1;
                o_free_req.waddr = r_node;
                o_free_req.wdata = r_size;
            end
            S_UP_RD: begin
                o_free_req.raddr = w_sib;
                o_wear_req.raddr = w_parent;
            end
            S_UP_WB: begin
                o_free_req.we    = 1'b1;
                o_free_req.waddr = w_parent;
                o_free_req.wdata = w_merged;
                o_wear_req.we    = (r_op == OP_ALLOC);
                o_wear_req.waddr = w_parent;
                o_wear_req.wdata = w_wmax;
            end
            S_DONE:   o_done = 1'b1;
            default: ;
        endcase
    end

    assign o_res.offset = r_offset;
    assign o_res.status = r_status;
    assign o_res.wear   = r_root_wear;

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_clr_size  <= SIZE_W'(CHUNKS);
            r_root_free <= SIZE_W'(CHUNKS);
            r_root_wear <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= w_clr_nxt;
                if (((w_clr_nxt + NODE_W'(1)) & w_clr_nxt) == '0)
                    r_clr_size <= r_clr_size >> 1;
            end
            // Root copies track every write to node zero
            if (o_free_req.we && o_free_req.waddr == '0)
                r_root_free <= o_free_req.wdata;
            if (o_wear_req.we && o_wear_req.waddr == '0)
                r_root_wear <= o_wear_req.wdata;
        end
    end

    // Walk datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_op    <= i_op;
                r_bytes <= i_bytes;
                r_foff  <= i_offset;
            end
            S_START: begin
                r_offset   <= '0;
                r_status   <= STAT_OK;
                r_cur_wear <= r_root_wear;
                if (r_op == OP_FREE) begin
                    r_node <= NODE_W'({1'b0, r_foff} + (OFF_W + 1)'(CHUNKS - 1));
                    r_size <= SIZE_W'(1);
                    if ({1'b0, r_foff} >= (OFF_W + 1)'(CHUNKS))
                        r_status <= STAT_IGN;
                end else begin
                    r_node <= '0;
                    r_size <= SIZE_W'(CHUNKS);
                    r_need <= SIZE_W'(1) << w_lvl;
                    r_left <= LVL_W'(LEVELS) - w_lvl;
                    if (w_oom)
                        r_status <= STAT_OOM;
                end
            end
            S_DN_DEC: begin
                r_node     <= w_go_right ? w_rchild : w_lchild;
                r_cur_wear <= w_go_right ? i_wear_rdata : r_lwear;
                if (w_go_right)
                    r_offset <= r_offset + OFF_W'(r_size >> 1);
                r_size <= r_size >> 1;
                r_left <= r_left - LVL_W'(1);
            end
            S_DN_RR: begin
                r_lfree <= i_free_rdata;
                r_lwear <= i_wear_rdata;
            end
            S_MARK: begin
                r_child_free <= '0;
                r_child_wear <= w_wear_inc;
            end
            S_FR_CHK: begin
                if (i_free_rdata != '0) begin
                    if (r_node == '0) begin
                        r_status <= STAT_IGN;
                    end else begin
                        r_node <= w_parent;
                        r_size <= r_size << 1;
                    end
                end
            end
            S_FR_SET: r_child_free <= r_size;
            S_UP_WB: begin
                r_node       <= w_parent;
                r_size       <= w_psize;
                r_child_free <= w_merged;
                r_child_wear <= w_wmax;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* hdl/buddy_allocator_wear_leveling_top.sv */
// Top level: stream ports, APB register, tree RAMs and result register.
`timescale 1ns / 1ps
`default_nettype none
// Binary buddy allocator over 1024 chunks of 128 bytes, with optional wear
// leveling. After reset a clearing pass loads both tree RAMs; s_axis_tready
// stays low until it ends. One item is worked at a time: an allocate walks
// down one tree level at a time (two child reads from the single-read
// free-size RAM, then the choice), marks the node and then, for each level
// back up, reads the sibling and writes back the parent; a free checks each
// node from the leaf up to the used node, restores it and updates each level
// from there to the root in the same way. Acceptance, request decode and
// result hand-off are states of their own, and an out-of-memory allocate goes
// from decode straight to hand-off. The result register frees the engine
// while a result waits downstream.
module buddy_allocator_wear_leveling_top
    import bawl_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [31:0]  s_axis_tdata,   // request_bytes[17:0], free_offset[27:18]
    input  wire         s_axis_tuser,   // operation: 0 alloc, 1 free
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // alloc_offset[9:0], status[11:10], max_wear[43:12]
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [2:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       r_wle;
    logic       r_ovalid;
    t_result    r_ores;
    logic       w_idle, w_done, w_take;
    t_result    w_res;
    t_free_req  w_free_req;
    t_wear_req  w_wear_req;
    logic [SIZE_W-1:0] w_free_rdata;
    logic [WEAR_W-1:0] w_wear_rdata;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {31'd0, r_wle} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_wle <= 1'b0;
        else if (psel && penable && pwrite && paddr == 3'd0)
            r_wle <= pwdata[0];
    end

    // Result register
    assign w_take        = !r_ovalid || m_axis_tready;
    assign s_axis_tready = w_idle;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_ores.wear, r_ores.status, r_ores.offset};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ovalid <= 1'b0;
        else if (w_done && w_take)
            r_ovalid <= 1'b1;
        else if (m_axis_tready)
            r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_take)
            r_ores <= w_res;
    end

    bawl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (s_axis_tvalid && w_idle),
        .i_op         (s_axis_tuser),
        .i_bytes      (s_axis_tdata[BYTES_W-1:0]),
        .i_offset     (s_axis_tdata[BYTES_W+OFF_W-1:BYTES_W]),
        .i_wle        (r_wle),
        .i_take       (w_take),
        .o_idle       (w_idle),
        .o_done       (w_done),
        .o_res        (w_res),
        .o_free_req   (w_free_req),
        .o_wear_req   (w_wear_req),
        .i_free_rdata (w_free_rdata),
        .i_wear_rdata (w_wear_rdata)
    );

    bawl_ram #(.WIDTH(SIZE_W), .DEPTH(NODES)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (w_free_req.we),
        .i_waddr (w_free_req.waddr),
        .i_wdata (w_free_req.wdata),
        .i_raddr (w_free_req.raddr),
        .o_rdata (w_free_rdata)
    );

    bawl_ram #(.WIDTH(WEAR_W), .DEPTH(NODES)) u_wear_ram (
        .i_clk   (i_clk),
        .i_we    (w_wear_req.we),
        .i_waddr (w_wear_req.waddr),
        .i_wdata (w_wear_req.wdata),
        .i_raddr (w_wear_req.raddr),
        .o_rdata (w_wear_rdata)
    );

`ifndef SYNTHESIS
    // One item at a time: after an accept the engine is busy
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while engine busy");

    // A finished result always lands in the output register
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done && w_take |=> m_axis_tvalid)
        else $error("finished result not presented");

    // Status code 3 is never produced
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[11:10] != 2'd3)
        else $error("illegal status code");
`endif

endmodule
`default_nettype wire
